[rtl/core/assert_macros.svh]
// assertion macros shared by the cipher rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent required in the cycle after the antecedent
`define CC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cc20_pkg.sv]
// shared types, constants and functions of the chacha20 stream cipher
// no dependencies; used by every module of the block
package cc20_pkg;

    localparam int DoubleRounds = 10;
    // four arx steps per column round and four per diagonal round
    localparam int StepCount    = 8 * DoubleRounds;
    localparam int StepW        = $clog2(StepCount);
    localparam logic [StepW-1:0] StepLast = StepW'(StepCount - 1);

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    localparam logic [31:0] Sigma0 = 32'h61707865;
    localparam logic [31:0] Sigma1 = 32'h3320646e;
    localparam logic [31:0] Sigma2 = 32'h79622d32;
    localparam logic [31:0] Sigma3 = 32'h6b206574;

    typedef enum logic [2:0] {
        CFG_KEY0       = 3'd0,
        CFG_KEY1       = 3'd1,
        CFG_KEY2       = 3'd2,
        CFG_KEY3       = 3'd3,
        CFG_NONCE_LOW  = 3'd4,
        CFG_NONCE_HIGH = 3'd5,
        CFG_START_CTR  = 3'd6
    } t_cfg_idx;

    typedef logic [15:0][31:0] t_block;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce_low;
        logic [31:0]      nonce_high;
    } t_cipher_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [31:0] counter;
    } t_gen_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_status;

    function automatic t_block load_words(t_cipher_cfg cfg, logic [31:0] ctr);
        t_block w;
        w[0] = Sigma0;
        w[1] = Sigma1;
        w[2] = Sigma2;
        w[3] = Sigma3;
        for (int k = 0; k < 4; k++) begin
            w[4 + 2*k]     = cfg.key[k][31:0];
            w[4 + 2*k + 1] = cfg.key[k][63:32];
        end
        w[12] = ctr;
        w[13] = cfg.nonce_low[31:0];
        w[14] = cfg.nonce_low[63:32];
        w[15] = cfg.nonce_high;
        return w;
    endfunction

    // word index of a quarter-round operand; diagonal rounds shift lanes by row
    function automatic logic [3:0] lane_idx(logic [1:0] row, logic [1:0] lane,
                                            logic diag);
        return {row, 2'(lane + (diag ? row : 2'd0))};
    endfunction

    function automatic logic [31:0] rotl_step(logic [31:0] v, logic [1:0] sub);
        logic [31:0] r;
        unique case (sub)
            2'd0: r = {v[15:0], v[31:16]};
            2'd1: r = {v[19:0], v[31:20]};
            2'd2: r = {v[23:0], v[31:24]};
            2'd3: r = {v[24:0], v[31:25]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/cc20_queue.sv]
// front end: small queue of accepted byte transactions with their end mark
// depends on cc20_pkg
module cc20_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cc20_pkg::t_item i_item,
    output cc20_pkg::t_item o_head,
    output logic           o_empty,
    input  logic           i_pop
);

    cc20_pkg::t_item r_mem [cc20_pkg::QueueDepth];
    logic [cc20_pkg::QueuePtrW-1:0] r_wr;
    logic [cc20_pkg::QueuePtrW-1:0] r_rd;
    logic [cc20_pkg::QueuePtrW:0]   r_count;
    logic push;
    logic pop;

    assign o_ready = (r_count != (cc20_pkg::QueuePtrW+1)'(cc20_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/cc20_block.sv]
// keystream block generator: one arx step of all four quarter rounds per cycle
// depends on cc20_pkg
module cc20_block (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cc20_pkg::t_cipher_cfg i_cfg,
    input  cc20_pkg::t_gen_req    i_req,
    output cc20_pkg::t_core_status o_st,
    output cc20_pkg::t_block      o_block
);

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_ADD
    } t_core_state;

    t_core_state            r_state;
    cc20_pkg::t_block       r_w;
    logic [31:0]            r_ctr;
    logic [cc20_pkg::StepW-1:0] r_step;
    logic                   r_done;

    cc20_pkg::t_block n_w;
    cc20_pkg::t_block w_load;
    cc20_pkg::t_block w_orig;
    logic             diag;
    logic [1:0]       sub;

    assign diag   = r_step[2];
    assign sub    = r_step[1:0];
    assign w_load = cc20_pkg::load_words(i_cfg, i_req.counter);
    assign w_orig = cc20_pkg::load_words(i_cfg, r_ctr);

    // lanes are independent within one step
    always_comb begin
        n_w = r_w;
        for (int j = 0; j < 4; j++) begin
            if (!sub[0]) begin
                n_w[cc20_pkg::lane_idx(2'd0, 2'(j), diag)] =
                    r_w[cc20_pkg::lane_idx(2'd0, 2'(j), diag)] +
                    r_w[cc20_pkg::lane_idx(2'd1, 2'(j), diag)];
                n_w[cc20_pkg::lane_idx(2'd3, 2'(j), diag)] = cc20_pkg::rotl_step(
                    r_w[cc20_pkg::lane_idx(2'd3, 2'(j), diag)] ^
                    n_w[cc20_pkg::lane_idx(2'd0, 2'(j), diag)], sub);
            end else begin
                n_w[cc20_pkg::lane_idx(2'd2, 2'(j), diag)] =
                    r_w[cc20_pkg::lane_idx(2'd2, 2'(j), diag)] +
                    r_w[cc20_pkg::lane_idx(2'd3, 2'(j), diag)];
                n_w[cc20_pkg::lane_idx(2'd1, 2'(j), diag)] = cc20_pkg::rotl_step(
                    r_w[cc20_pkg::lane_idx(2'd1, 2'(j), diag)] ^
                    n_w[cc20_pkg::lane_idx(2'd2, 2'(j), diag)], sub);
            end
        end
    end

    assign o_st.busy = (r_state != CS_IDLE);
    assign o_st.done = r_done;
    assign o_block   = r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                CS_IDLE: begin
                    if (i_req.start) begin
                        r_w     <= w_load;
                        r_ctr   <= i_req.counter;
                        r_step  <= '0;
                        r_state <= CS_ROUND;
                    end
                end
                CS_ROUND: begin
                    r_w    <= n_w;
                    r_step <= r_step + 1'b1;
                    if (r_step == cc20_pkg::StepLast) begin
                        r_state <= CS_ADD;
                    end
                end
                CS_ADD: begin
                    // feed-forward of the loaded state
                    for (int i = 0; i < 16; i++) begin
                        r_w[i] <= r_w[i] + w_orig[i];
                    end
                    r_done  <= 1'b1;
                    r_state <= CS_IDLE;
                end
                default: r_state <= CS_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/cc20_back.sv]
// back end: message tracking, block requests, xor and output register
// depends on cc20_pkg and assert_macros.svh
`include "assert_macros.svh"

module cc20_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [31:0]            i_start_counter,
    input  cc20_pkg::t_item        i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    output cc20_pkg::t_gen_req     o_req,
    input  cc20_pkg::t_core_status i_st,
    input  cc20_pkg::t_block       i_block,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_out_last
);

    typedef enum logic {
        BS_FETCH,
        BS_GEN
    } t_back_state;

    t_back_state r_state;
    logic [5:0]  r_pos;
    logic [31:0] r_ctr;
    logic        r_mid;
    logic        r_fresh;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic [5:0]  pos_eff;
    logic [31:0] ctr_eff;
    logic [5:0]  n_pos;
    logic        need_blk;
    logic        slot_free;
    logic        gen_start;
    logic        pop;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    // a new message starts from the configured counter at position zero
    assign pos_eff   = r_mid ? r_pos : '0;
    assign ctr_eff   = r_mid ? r_ctr : i_start_counter;
    assign n_pos     = pos_eff + 6'd1;
    assign need_blk  = (pos_eff == '0) && !r_fresh;
    assign slot_free = !r_out_valid || i_out_ready;
    assign gen_start = (r_state == BS_FETCH) && !i_empty && need_blk;
    assign pop       = (r_state == BS_FETCH) && !i_empty && !need_blk && slot_free;
    assign ks_word   = i_block[pos_eff[5:2]];
    assign ks_byte   = ks_word[{pos_eff[1:0], 3'b000} +: 8];

    assign o_pop         = pop;
    assign o_req.start   = gen_start;
    assign o_req.counter = ctr_eff;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_last    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_FETCH;
            r_pos       <= '0;
            r_ctr       <= '0;
            r_mid       <= 1'b0;
            r_fresh     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            unique case (r_state)
                BS_FETCH: begin
                    if (gen_start) begin
                        r_mid   <= 1'b1;
                        r_ctr   <= ctr_eff;
                        r_pos   <= '0;
                        r_state <= BS_GEN;
                    end
                end
                BS_GEN: begin
                    if (i_st.done) begin
                        r_fresh <= 1'b1;
                        r_state <= BS_FETCH;
                    end
                end
                default: r_state <= BS_FETCH;
            endcase

            if (pop) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= i_head.data ^ ks_byte;
                r_out_last  <= i_head.eom;
                r_fresh     <= 1'b0;
                if (i_head.eom) begin
                    r_pos <= '0;
                    r_mid <= 1'b0;
                end else begin
                    r_pos <= n_pos;
                    r_ctr <= (n_pos == '0) ? ctr_eff + 32'd1 : ctr_eff;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `CC_ASSERT(a_start_core_idle, i_clk, i_rst_n, !(gen_start && i_st.busy), "block request while generator busy")
    `CC_ASSERT_NEXT(a_pop_fills_out, i_clk, i_rst_n, pop, r_out_valid, "consumed transaction left no result")
    `CC_ASSERT(a_fresh_at_start, i_clk, i_rst_n, !r_fresh || (r_pos == '0 && r_mid), "fresh block away from block start")
    `CC_ASSERT_NEXT(a_done_marks_fresh, i_clk, i_rst_n, i_st.done, r_fresh, "finished block not marked fresh")

endmodule

[rtl/core/chacha20_stream_cipher.sv]
// data path: an input transaction passes the queue memory and the output register;
// the first byte of each 64-byte block also waits for a new keystream block,
// while the shared arx datapath runs one step of four quarter rounds per cycle.
// throughput: one byte per cycle in a block unless queue empty or output stalled.
// reset: synchronous active low; clears configuration to zero, empties the queue
// and restarts message state; no clearing pass is needed.
module chacha20_stream_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    cc20_pkg::t_cipher_cfg  r_cfg;
    logic [31:0]            r_start_ctr;

    cc20_pkg::t_item        in_item;
    cc20_pkg::t_item        head;
    logic                   q_empty;
    logic                   q_pop;
    cc20_pkg::t_gen_req     gen_req;
    cc20_pkg::t_core_status core_st;
    cc20_pkg::t_block       ks_block;

    assign o_cfg_ready  = 1'b1;
    assign in_item.data = s_axis_tdata;
    assign in_item.eom  = s_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_start_ctr <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cc20_pkg::CFG_KEY0:       r_cfg.key[0]     <= i_cfg_data;
                cc20_pkg::CFG_KEY1:       r_cfg.key[1]     <= i_cfg_data;
                cc20_pkg::CFG_KEY2:       r_cfg.key[2]     <= i_cfg_data;
                cc20_pkg::CFG_KEY3:       r_cfg.key[3]     <= i_cfg_data;
                cc20_pkg::CFG_NONCE_LOW:  r_cfg.nonce_low  <= i_cfg_data;
                cc20_pkg::CFG_NONCE_HIGH: r_cfg.nonce_high <= i_cfg_data[31:0];
                cc20_pkg::CFG_START_CTR:  r_start_ctr      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    cc20_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_head  (head),
        .o_empty (q_empty),
        .i_pop   (q_pop)
    );

    cc20_block u_block (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (gen_req),
        .o_st    (core_st),
        .o_block (ks_block)
    );

    cc20_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start_counter (r_start_ctr),
        .i_head          (head),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_req           (gen_req),
        .i_st            (core_st),
        .i_block         (ks_block),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_out_byte      (m_axis_tdata),
        .o_out_last      (m_axis_tlast)
    );

endmodule
